[hw/rtl/mfd_pkg.sv]
`timescale 1ns / 1ps
package mfd_pkg;

   localparam int Inputs      = 8;
   localparam int HiddenOne   = 12;
   localparam int HiddenTwo   = 64;
   localparam int HiddenThree = 64;
   localparam int Outputs     = 5;
   localparam int ParamDepth  = 8192;
   localparam int MaxResults  = 5;

   localparam int AW = 13;

   localparam int OffBase = 0;
   localparam int MinBase = OffBase + Inputs;
   localparam int RngBase = MinBase + Outputs + Inputs;
   localparam int W1Base  = RngBase + Outputs + Inputs;
   localparam int B1Base  = W1Base + Inputs * HiddenOne;
   localparam int W2Base  = B1Base + HiddenOne;
   localparam int B2Base  = W2Base + HiddenOne * HiddenTwo;
   localparam int W3Base  = B2Base + HiddenTwo;
   localparam int B3Base  = W3Base + HiddenTwo * HiddenThree;
   localparam int W4Base  = B3Base + HiddenThree;
   localparam int B4Base  = W4Base + HiddenThree * Outputs;

   localparam int NumResults = (Outputs < MaxResults) ? Outputs : MaxResults;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_WRITE    = 4'd1,  // parameter store write
      OP_OFFSET   = 4'd2,  // read offset for a sample
      OP_SAMPLE   = 4'd3,  // subtract offset, store sample
      OP_RD       = 4'd4,  // issue parameter read
      OP_SCALE_A  = 4'd5,  // diff = sample*2^16 - min
      OP_SCALE_B  = 4'd6,  // product with reciprocal, round, store
      OP_CLR      = 4'd7,  // clear accumulator and product
      OP_MAC      = 4'd8,  // multiply weight by activation, accumulate previous product
      OP_ACC      = 4'd9,  // accumulate product
      OP_BIAS     = 4'd10, // add bias*2^16
      OP_STORE    = 4'd11, // round, relu, store activation
      OP_OUT_MUL  = 4'd12, // acc = act * range
      OP_OUT_RES  = 4'd13  // round result into output register
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [AW-1:0]   addr;     // parameter address
      logic [31:0]     wdata;
      logic [7:0]      act_rd;   // activation read index, bank bit on top
      logic [7:0]      act_wr;
      logic [2:0]      smp_idx;
      logic [23:0]     smp_raw;
   } cmd_type;

   function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
      if (a[63] && b[63] && !s[63]) return {1'b1, {63{1'b0}}};
      return s;
   endfunction

   function automatic logic signed [31:0] round_q(logic signed [63:0] v);
      logic signed [63:0] r;
      logic signed [47:0] q;
      r = sat_add64(v, 64'sd32768);
      q = r[63:16];
      if (q > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (q < -48'sh0000_8000_0000) return 32'sh8000_0000;
      return q[31:0];
   endfunction

endpackage

[hw/rtl/mfd_datapath.sv]
`timescale 1ns / 1ps
module mfd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  mfd_pkg::cmd_type   cmd,
   output logic signed [31:0] result
);
   import mfd_pkg::*;

   logic signed [31:0] pmem [ParamDepth];
   logic signed [31:0] amem [256];
   logic signed [24:0] smem [8];

   logic signed [31:0] prd_ff;
   logic signed [31:0] ard_ff;
   logic signed [24:0] srd_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [31:0] result_ff, result_in;
   logic signed [24:0] sdiff;
   logic signed [31:0] rq;

   // memories: one write, registered reads
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         pmem[cmd.addr] <= cmd.wdata;
      end
      prd_ff <= pmem[cmd.addr];
      ard_ff <= amem[cmd.act_rd];
      srd_ff <= smem[cmd.smp_idx];
      if (cmd.op == OP_STORE || cmd.op == OP_SCALE_B) begin
         amem[cmd.act_wr] <= (rq < 0) && (cmd.op == OP_STORE) ? 32'sd0 : rq;
      end
      if (cmd.op == OP_SAMPLE) begin
         smem[cmd.smp_idx] <= sdiff;
      end
   end

   always_comb begin
      logic signed [33:0] d;
      d = $signed({10'd0, cmd.smp_raw}) - 34'(prd_ff);
      if (d > 34'sd16777215) sdiff = 25'sd16777215;
      else if (d < -34'sd16777216) sdiff = -25'sd16777216;
      else sdiff = d[24:0];
   end

   assign rq = (cmd.op == OP_SCALE_B) ? round_q(prod_ff) : round_q(acc_ff);

   always_comb begin
      logic signed [48:0] dd;
      dd = ($signed({srd_ff, 16'd0}) >>> 0) - 49'(prd_ff);
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      diff_in   = diff_ff;
      result_in = result_ff;
      case (cmd.op)
         OP_SCALE_A: begin
            if (dd > 49'sh0_7FFF_FFFF) diff_in = 32'sh7FFF_FFFF;
            else if (dd < -49'sh0_8000_0000) diff_in = 32'sh8000_0000;
            else diff_in = dd[31:0];
         end
         OP_SCALE_B: prod_in = 64'(diff_ff) * 64'(prd_ff);
         OP_CLR: begin
            acc_in  = '0;
            prod_in = '0;
         end
         OP_MAC: begin
            prod_in = 64'(prd_ff) * 64'(ard_ff);
            acc_in  = sat_add64(acc_ff, prod_ff);
         end
         OP_ACC:     acc_in  = sat_add64(acc_ff, prod_ff);
         OP_BIAS:    acc_in  = sat_add64(acc_ff, {{16{prd_ff[31]}}, prd_ff, 16'd0});
         OP_OUT_MUL: acc_in  = 64'(ard_ff) * 64'(prd_ff);
         OP_OUT_RES: result_in = round_q(sat_add64(acc_ff,
                                 {{16{prd_ff[31]}}, prd_ff, 16'd0}));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      prod_ff   <= prod_in;
      diff_ff   <= diff_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

[hw/rtl/mfd_ctrl.sv]
`timescale 1ns / 1ps
module mfd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [72:0]        req_tdata,
   output mfd_pkg::cmd_type   cmd,
   output logic               res_valid,
   output logic [2:0]         res_index,
   output logic               res_last,
   input  logic               res_free
);
   import mfd_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SMP   = 8'b0000_0010,
      S_SCALE = 8'b0000_0100,
      S_LAYER = 8'b0000_1000,
      S_OUT   = 8'b0001_0000,
      S_EMIT  = 8'b0010_0000,
      S_WAIT  = 8'b0100_0000,
      S_OFF   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  layer_ff, layer_in;   // 0..3
   logic [6:0]  node_ff, node_in;     // target node
   logic [7:0]  src_ff, src_in;       // source index, 0..nin+5
   logic [2:0]  sidx_ff, sidx_in;
   logic [23:0] sraw_ff, sraw_in;

   logic        acc;
   logic [7:0]  nin, nout;
   logic [AW-1:0] wbase, bbase;
   logic        sbank; // source bank

   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      case (layer_ff)
         3'd0: begin nin = 8'(Inputs); nout = 8'(HiddenOne);
                     wbase = AW'(W1Base); bbase = AW'(B1Base); end
         3'd1: begin nin = 8'(HiddenOne); nout = 8'(HiddenTwo);
                     wbase = AW'(W2Base); bbase = AW'(B2Base); end
         3'd2: begin nin = 8'(HiddenTwo); nout = 8'(HiddenThree);
                     wbase = AW'(W3Base); bbase = AW'(B3Base); end
         default: begin nin = 8'(HiddenThree); nout = 8'(Outputs);
                     wbase = AW'(W4Base); bbase = AW'(B4Base); end
      endcase
   end
   assign sbank = layer_ff[0];

   always_comb begin
      logic [AW-1:0] widx;
      state_in = state_ff;
      layer_in = layer_ff;
      node_in  = node_ff;
      src_in   = src_ff;
      sidx_in  = sidx_ff;
      sraw_in  = sraw_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.smp_idx = sidx_ff;
      cmd.smp_raw = sraw_ff;
      res_valid = 1'b0;
      res_index = node_ff[2:0];
      res_last  = (node_ff == 7'(NumResults - 1));
      widx = wbase + AW'(src_ff - 8'd1) * AW'(nout) + AW'(node_ff);
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_tdata[0] == CMD_LOAD) begin
                  cmd.op    = OP_WRITE;
                  cmd.addr  = req_tdata[13:1];
                  cmd.wdata = req_tdata[45:14];
               end else begin
                  sidx_in  = req_tdata[48:46];
                  sraw_in  = req_tdata[72:49];
                  state_in = S_OFF;
               end
            end
         end
         S_OFF: begin
            cmd.op   = OP_OFFSET;
            cmd.addr = AW'(OffBase) + AW'(sidx_ff);
            state_in = S_SMP;
         end
         S_SMP: begin
            cmd.op   = OP_SAMPLE;
            cmd.addr = AW'(OffBase) + AW'(sidx_ff);
            if (sidx_ff == 3'(Inputs - 1)) begin
               state_in = S_SCALE;
               src_in   = '0;
               node_in  = '0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCALE: begin
            // per input: 0 read min, 1 diff + read rng, 2 product, 3 store
            cmd.smp_idx = node_ff[2:0];
            cmd.act_wr  = {1'b0, 7'(node_ff)};
            case (src_ff[1:0])
               2'd0: begin cmd.op = OP_RD;
                  cmd.addr = AW'(MinBase + Outputs) + AW'(node_ff); end
               2'd1: begin cmd.op = OP_SCALE_A;
                  cmd.addr = AW'(RngBase + Outputs) + AW'(node_ff); end
               2'd2: cmd.op = OP_SCALE_B;
               default: cmd.op = OP_SCALE_B;
            endcase
            // the last step writes the rounded product
            if (src_ff[1:0] == 2'd3) cmd.op = OP_SCALE_B;
            src_in = src_ff + 8'd1;
            if (src_ff[1:0] == 2'd3) begin
               src_in = '0;
               if (node_ff == 7'(Inputs - 1)) begin
                  node_in  = '0;
                  layer_in = '0;
                  state_in = S_LAYER;
               end else begin
                  node_in = node_ff + 7'd1;
               end
            end
         end
         S_LAYER: begin
            // fixed schedule per node: 0 clears; step k (1..nin) reads weight
            // and activation k-1 while the MAC multiplies pair k-2 and adds
            // product k-3; then last add with bias read, bias add, store, idle
            cmd.act_wr = {~sbank, node_ff};
            if (src_ff >= 8'd1 && src_ff <= nin) begin
               cmd.addr   = widx;
               cmd.act_rd = {sbank, 7'(src_ff - 8'd1)};
            end else if (src_ff == nin + 8'd2) begin
               cmd.addr = bbase + AW'(node_ff);
            end
            if (src_ff == 8'd0) cmd.op = OP_CLR;
            else if (src_ff == 8'd1) cmd.op = OP_RD;
            else if (src_ff <= nin + 8'd1) cmd.op = OP_MAC;
            else if (src_ff == nin + 8'd2) cmd.op = OP_ACC;
            else if (src_ff == nin + 8'd3) cmd.op = OP_BIAS;
            else if (src_ff == nin + 8'd4) cmd.op = OP_STORE;
            else cmd.op = OP_NONE;
            src_in = src_ff + 8'd1;
            if (src_ff == nin + 8'd5) begin
               src_in = '0;
               if (node_ff == 7'(nout - 8'd1)) begin
                  node_in = '0;
                  if (layer_ff == 3'd3) state_in = S_OUT;
                  else layer_in = layer_ff + 3'd1;
               end else begin
                  node_in = node_ff + 7'd1;
               end
            end
         end
         S_OUT: begin
            // 0 read rng/act, 1 mul + read min, 2 round result, 3 idle
            cmd.act_rd = {1'b0, node_ff};
            case (src_ff[2:0])
               3'd0: begin cmd.op = OP_RD; cmd.addr = AW'(RngBase) + AW'(node_ff); end
               3'd1: begin cmd.op = OP_OUT_MUL;
                  cmd.addr = AW'(MinBase) + AW'(node_ff); end
               3'd2: cmd.op = OP_OUT_RES;
               default: cmd.op = OP_NONE;
            endcase
            src_in = src_ff + 8'd1;
            if (src_ff[2:0] == 3'd3) begin
               src_in = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_free) state_in = S_WAIT;
         end
         S_WAIT: begin
            if (node_ff == 7'(NumResults - 1)) begin
               node_in  = '0;
               state_in = S_IDLE;
            end else begin
               node_in  = node_ff + 7'd1;
               state_in = S_OUT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // advance state and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         layer_ff <= '0;
         node_ff  <= '0;
         src_ff   <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         node_ff  <= node_in;
         src_ff   <= src_in;
      end
      sidx_ff <= sidx_in;
      sraw_ff <= sraw_in;
   end
endmodule

[hw/rtl/mlp_force_decoder.sv]
`timescale 1ns / 1ps
// mlp_force_decoder: ReLU network that turns eight pressure samples into
// five Q16.16 force values.
// req channel: tdata = {sample_raw, sample_index, param_word, param_addr,
// cmd}. cmd 0 writes one parameter word; cmd 1 delivers a sample, offset
// removed and stored. Sample index 7 starts a full evaluation.
// rsp channel: tdata = force_value, tuser = force_index, tlast marks the
// fifth result of an evaluation.
// A load is written in the cycle it is accepted; a sample passes through
// the offset read and sample store states. An evaluation runs one shared
// multiply-accumulate over every weight, one weight per cycle, with clear,
// bias and store steps per node, after the input scaling. Each result is
// computed, then handed to the output register once that is free, and shows
// on rsp in the cycle after the hand-off.
// The controller works on one transaction at a time; req_tready is low while
// a sample is stored, an evaluation runs or a result waits for the output register.
// The output register holds its transaction while rsp_tready is low; once
// the last result sits there, new requests are taken again.
// Reset clears the controller, output register and accumulator; memories
// are not cleared and must be loaded before use.
module mlp_force_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // cmd, param_addr, param_word, sample_index, sample_raw
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // force_value
   output logic [2:0]  rsp_tuser,   // force_index
   output logic        rsp_tlast
);
   import mfd_pkg::*;

   cmd_type            cmd;
   logic signed [31:0] result;
   logic               res_valid;
   logic [2:0]         res_index;
   logic               res_last;
   logic               res_free;
   logic               res_take;

   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_data_ff, out_data_in;
   logic [2:0]         out_index_ff, out_index_in;
   logic               out_last_ff, out_last_in;

   // controller sequences the shared multiply-accumulate datapath
   mfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata[72:0]),
      .cmd        (cmd),
      .res_valid  (res_valid),
      .res_index  (res_index),
      .res_last   (res_last),
      .res_free   (res_free)
   );

   mfd_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (result)
   );

   // output register: take a result when empty or being drained
   assign res_free = !out_valid_ff || rsp_tready;
   assign res_take = res_valid && res_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (res_take) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
         out_index_in = res_index;
         out_last_in  = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_index_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_no_req_while_out: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready) else $error("input taken during output");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == 3'(NumResults - 1)))
      else $error("tlast on wrong index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
`endif
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the pressure-to-force decoder.
// A queue of pending transactions is filled up front: a full parameter load, a short
// directed run that hits the saturation corners, then random sample frames with
// scattered parameter rewrites. A clocked driver offers them with random gaps, a
// clocked monitor predicts every accepted request and checks each response in order.
module tb_top;
   import mfd_pkg::*;

   localparam int ParamEnd  = B4Base + Outputs;  // first address past the network
   localparam int IdleLimit = 40000;              // cycles without any transaction
   localparam int HoldOff   = 2000;

   typedef struct {
      logic [2:0]  index;
      logic [31:0] value;
      logic        last;
   } force_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // cmd, param_addr, param_word, sample_index, sample_raw
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // force_value
   logic [2:0]  rsp_tuser;        // force_index
   logic        rsp_tlast;

   mlp_force_decoder dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the block's memories
   int      params [ParamDepth];
   int      samples [8];
   int      act [2][128];
   force_type force_q [$];
   logic [79:0] pending [$];
   int      offsets [8];  // stimulus side view of the offsets
   int      errors = 0;
   int      rsp_count = 0;
   logic    req_done = 1'b0;

   function automatic longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a >= 0 && b >= 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
      return s;
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // Q32.32 back to Q16.16, round half up
   function automatic int to_q16(longint v);
      longint r;
      r = sadd(v, 64'sd32768);
      return clamp32(r >>> 16);
   endfunction

   function automatic void dense_relu(int src, int nin, int nout, int wbase, int bbase);
      longint acc;
      int     v;
      for (int i = 0; i < nout; i++) begin
         acc = 0;
         for (int j = 0; j < nin; j++)
            acc = sadd(acc, longint'(params[wbase + j * nout + i]) * longint'(act[src][j]));
         acc = sadd(acc, longint'(params[bbase + i]) * 65536);
         v = to_q16(acc);
         act[1 - src][i] = (v < 0) ? 0 : v;
      end
   endfunction

   function automatic void decode_forces();
      longint diff;
      longint acc;
      force_type f;
      for (int i = 0; i < Inputs; i++) begin
         diff = longint'(samples[i]) * 65536 - longint'(params[MinBase + Outputs + i]);
         act[0][i] = to_q16(longint'(clamp32(diff)) *
                            longint'(params[RngBase + Outputs + i]));
      end
      dense_relu(0, Inputs, HiddenOne, W1Base, B1Base);
      dense_relu(1, HiddenOne, HiddenTwo, W2Base, B2Base);
      dense_relu(0, HiddenTwo, HiddenThree, W3Base, B3Base);
      dense_relu(1, HiddenThree, Outputs, W4Base, B4Base);
      for (int i = 0; i < NumResults; i++) begin
         acc = longint'(act[0][i]) * longint'(params[RngBase + i]);
         acc = sadd(acc, longint'(params[MinBase + i]) * 65536);
         f.index = 3'(i);
         f.value = to_q16(acc);
         f.last  = (i == NumResults - 1);
         force_q.push_back(f);
      end
   endfunction

   // apply one accepted request to the shadow state
   function automatic void apply_request(logic [79:0] d);
      longint diff;
      logic [2:0] idx;
      if (d[0] == CMD_LOAD) begin
         params[d[13:1]] = d[45:14];
      end else begin
         idx  = d[48:46];
         diff = longint'(d[72:49]) - longint'(params[idx]);
         if (diff > 16777215) diff = 16777215;
         if (diff < -16777216) diff = -16777216;
         samples[idx] = int'(diff);
         if (idx == 3'(Inputs - 1)) decode_forces();
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_load(int addr, int word);
      logic [79:0] d;
      d = '0;
      d[0]     = CMD_LOAD;
      d[13:1]  = 13'(addr);
      d[45:14] = word;
      pending.push_back(d);
      if (addr < Inputs) offsets[addr] = word;
   endfunction

   function automatic void queue_sample(int idx, int raw);
      logic [79:0] d;
      d = '0;
      d[0]     = CMD_SAMPLE;
      d[48:46] = 3'(idx);
      d[72:49] = 24'(raw);
      d[45:14] = $urandom();    // ignored fields carry noise
      d[13:1]  = 13'($urandom());
      pending.push_back(d);
   endfunction

   function automatic int small_word();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // sample close to the channel offset so scaling stays in range
   function automatic int near_raw(int ch);
      longint r;
      r = longint'(offsets[ch]) + $urandom_range(0, 2000);
      if (r > 24'hFF_FFFF) r = 24'hFF_FFFF;
      if (r < 0) r = 0;
      return int'(r);
   endfunction

   // driver: change inputs on the falling edge, hold until accepted
   logic req_fire = 1'b0;
   int   req_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending.size() != 0) begin
            req_tdata  <= pending.pop_front();
            req_tvalid <= 1'b1;
            req_gap    <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off once results flow
   int   rsp_gap = 0;
   int   hold = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold > 0) begin
         hold <= hold - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= 7) begin
         hold <= HoldOff;
         hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // monitor: predict on request, compare on response
   force_type exp_f;
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) apply_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (force_q.size() == 0) begin
            $display("%0t: unexpected response index %0d value %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            exp_f = force_q.pop_front();
            if (rsp_tuser !== exp_f.index || rsp_tdata !== exp_f.value ||
                rsp_tlast !== exp_f.last) begin
               $display("%0t: mismatch expected index %0d value %h last %b, got %0d %h %b",
                        $time, exp_f.index, exp_f.value, exp_f.last,
                        rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   int idle = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle <= 0;
      end else if (idle >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle <= idle + 1;
      end
   end

   initial begin
      // full parameter image: offsets, scaling, then the network
      for (int i = 0; i < Inputs; i++) queue_load(OffBase + i, $urandom_range(0, 24'hF0_0000));
      for (int i = 0; i < Outputs; i++) begin
         queue_load(MinBase + i, small_word());
         queue_load(RngBase + i, $urandom_range(32768, 4 * 65536));
      end
      for (int i = 0; i < Inputs; i++) begin
         queue_load(MinBase + Outputs + i, $urandom_range(0, 65536 * 200));
         queue_load(RngBase + Outputs + i, $urandom_range(32, 64));
      end
      for (int a = W1Base; a < ParamEnd; a++) begin
         if ((a >= B1Base && a < W2Base) || (a >= B2Base && a < W3Base) ||
             (a >= B3Base && a < W4Base) || a >= B4Base)
            queue_load(a, $urandom_range(0, 16384));  // biases lean positive
         else
            queue_load(a, small_word());
      end

      // directed: raw extremes, offsets that force both saturation limits
      for (int i = 0; i < Inputs; i++) queue_sample(i, (i % 2) ? 24'hFF_FFFF : 0);
      queue_load(OffBase + 2, 32'h8000_0000);   // raw minus offset clips high
      queue_load(OffBase + 3, 32'h7FFF_FFFF);   // clips low
      queue_load(ParamDepth - 1, 32'hFFFF_FFFF);
      queue_load(W4Base, 32'h7FFF_FFFF);        // drive the accumulator hard
      queue_load(RngBase, 32'h7FFF_FFFF);
      queue_sample(2, 0);
      queue_sample(3, 24'hFF_FFFF);
      queue_sample(7, 24'hFF_FFFF);
      queue_load(MinBase + 1, 32'h8000_0000);
      queue_sample(7, 0);
      queue_load(OffBase + 2, $urandom_range(0, 24'hF0_0000));
      queue_load(OffBase + 3, $urandom_range(0, 24'hF0_0000));
      queue_load(W4Base, small_word());
      queue_load(RngBase, 65536);
      queue_load(MinBase + 1, 0);

      // random frames: mostly ordered samples near their offsets
      for (int f = 0; f < 12; f++) begin
         for (int k = $urandom_range(0, 3); k > 0; k--) begin
            int a;
            a = $urandom_range(W1Base, ParamDepth - 1);
            queue_load(a, (a >= ParamEnd) ? int'($urandom()) : small_word());
         end
         for (int i = 0; i < Inputs; i++) begin
            int ch;
            ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : i;
            queue_sample(ch, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                         : near_raw(ch));
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // drain: all requests taken, all results seen, then a settling margin
      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (force_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_datapath.sv
hw/rtl/mfd_ctrl.sv
hw/rtl/mlp_force_decoder.sv
test/tb_top.sv
